/* hdl/sorted_list_merge_core_macros.svh */
// Assertion macros used by the back part of the merge core.
`ifndef SORTED_LIST_MERGE_CORE_MACROS_SVH
`define SORTED_LIST_MERGE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SLM_ASSERT_NOW(label, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SLM_ASSERT_NEXT(label, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
        else $error(msg);

`endif

/* hdl/slm_pkg.sv */
// Types and codes shared by the merge core modules.
`timescale 1ns / 1ps

package slm_pkg;

    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_MERGE  = 2'd2;

    localparam int KEY_W = 32;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [KEY_W-1:0] value;
    } slm_in_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] merged_value;
        logic                    last;
        logic                    empty_res;
        logic                    overflow;
    } slm_out_t;

    typedef enum logic [1:0] {
        SLM_OP_LOAD_A,
        SLM_OP_LOAD_B,
        SLM_OP_MERGE
    } slm_op_t;

    typedef struct packed {
        slm_op_t          op;
        logic [KEY_W-1:0] value;
        logic             ovf;
    } slm_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } slm_q_status_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_MERGE
    } slm_back_state_t;

endpackage

/* hdl/slm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module slm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]     wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]     rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/slm_queue.sv */
// Two-entry command queue between the front and back parts.
`timescale 1ns / 1ps

module slm_queue
    import slm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  slm_cmd_t      push_data,
    input  logic          pop,
    output slm_cmd_t      pop_data,
    output slm_q_status_t status
);

    slm_cmd_t   entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    always_comb
    begin
        do_push     = push && (fill_reg != 2'd2);
        do_pop      = pop && (fill_reg != 2'd0);
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign status.full  = (fill_reg == 2'd2);
    assign status.empty = (fill_reg == 2'd0);

endmodule

/* hdl/slm_front.sv */
// Front part: accepts input items, tracks list fill and overflow, queues commands.
`timescale 1ns / 1ps

module slm_front
    import slm_pkg::*;
#(
    parameter int LIST_DEPTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  slm_in_t       in_data,
    input  slm_q_status_t q_status,
    output logic          q_push,
    output slm_cmd_t      q_data,
    input  logic          merge_done
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic          ovf_reg, ovf_next;
    logic          busy_reg, busy_next;
    logic          accept;

    always_comb
    begin
        in_ready   = !busy_reg && !q_status.full;
        accept     = in_valid && in_ready;
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        ovf_next   = ovf_reg;
        busy_next  = busy_reg && !merge_done;
        q_push     = 1'b0;
        q_data.op    = SLM_OP_LOAD_A;
        q_data.value = in_data.value;
        q_data.ovf   = ovf_reg;
        if (accept)
        begin
            case (in_data.kind)
                KIND_LOAD_A:
                begin
                    if (cnt_a_reg >= CW'(LIST_DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        q_push     = 1'b1;
                        cnt_a_next = cnt_a_reg + CW'(1);
                    end
                end
                KIND_LOAD_B:
                begin
                    q_data.op = SLM_OP_LOAD_B;
                    if (cnt_b_reg >= CW'(LIST_DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        q_push     = 1'b1;
                        cnt_b_next = cnt_b_reg + CW'(1);
                    end
                end
                KIND_MERGE:
                begin
                    // Hold off input until the back part has read out both lists.
                    q_data.op  = SLM_OP_MERGE;
                    q_push     = 1'b1;
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                    ovf_next   = 1'b0;
                    busy_next  = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ovf_reg   <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            ovf_reg   <= ovf_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

/* hdl/slm_back.sv */
// Back part: writes loads into the list RAMs and runs the merge into the output register.
`timescale 1ns / 1ps

`include "sorted_list_merge_core_macros.svh"

module slm_back
    import slm_pkg::*;
#(
    parameter int LIST_DEPTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    input  slm_q_status_t q_status,
    input  slm_cmd_t      q_data,
    output logic          q_pop,
    output logic          merge_done,
    output logic          out_valid,
    input  logic          out_ready,
    output slm_out_t      out_data
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int SW = CW + 1;

    slm_back_state_t state_reg, state_next;
    logic [CW-1:0]   wa_reg, wa_next, wb_reg, wb_next;
    logic [CW-1:0]   ia_reg, ia_next, ib_reg, ib_next;
    logic            ovf_reg, ovf_next;
    logic            desc_reg;
    logic            out_valid_reg, out_valid_next;
    slm_out_t        out_data_reg, res;
    logic            emit, step, a_left, b_left, take_a, cmp;
    logic            we_a, we_b;
    logic [KEY_W-1:0] head_a, head_b;
    logic [SW-1:0]   total, pos;

    slm_ram #(.WIDTH(KEY_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .clk     (clk),
        .wr_en   (we_a),
        .wr_addr (wa_reg[AW-1:0]),
        .wr_data (q_data.value),
        .rd_addr (ia_next[AW-1:0]),
        .rd_data (head_a)
    );

    slm_ram #(.WIDTH(KEY_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .clk     (clk),
        .wr_en   (we_b),
        .wr_addr (wb_reg[AW-1:0]),
        .wr_data (q_data.value),
        .rd_addr (ib_next[AW-1:0]),
        .rd_data (head_b)
    );

    always_comb
    begin
        state_next = state_reg;
        wa_next    = wa_reg;
        wb_next    = wb_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        ovf_next   = ovf_reg;
        q_pop      = 1'b0;
        we_a       = 1'b0;
        we_b       = 1'b0;
        emit       = 1'b0;
        merge_done = 1'b0;
        step       = !out_valid_reg || out_ready;
        a_left     = ia_reg < wa_reg;
        b_left     = ib_reg < wb_reg;
        total      = SW'(wa_reg) + SW'(wb_reg);
        pos        = SW'(ia_reg) + SW'(ib_reg) + SW'(1);
        cmp        = desc_reg ? ($signed(head_b) <= $signed(head_a))
                              : ($signed(head_a) <= $signed(head_b));
        take_a     = a_left && (!b_left || cmp);
        res.merged_value = take_a ? $signed(head_a) : $signed(head_b);
        res.last         = (pos == total);
        res.empty_res    = 1'b0;
        res.overflow     = ovf_reg;
        case (state_reg)
            BACK_IDLE:
            begin
                // Keep both read ports on entry 0 so the heads are ready at merge start.
                ia_next = '0;
                ib_next = '0;
                if (!q_status.empty)
                begin
                    q_pop = 1'b1;
                    case (q_data.op)
                        SLM_OP_LOAD_A:
                        begin
                            we_a    = 1'b1;
                            wa_next = wa_reg + CW'(1);
                        end
                        SLM_OP_LOAD_B:
                        begin
                            we_b    = 1'b1;
                            wb_next = wb_reg + CW'(1);
                        end
                        SLM_OP_MERGE:
                        begin
                            ovf_next   = q_data.ovf;
                            state_next = BACK_MERGE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BACK_MERGE:
            begin
                if (step)
                begin
                    emit = 1'b1;
                    if (total == '0)
                    begin
                        res.merged_value = '0;
                        res.last         = 1'b1;
                        res.empty_res    = 1'b1;
                    end
                    else if (take_a)
                    begin
                        ia_next = ia_reg + CW'(1);
                    end
                    else
                    begin
                        ib_next = ib_reg + CW'(1);
                    end
                    if (res.last)
                    begin
                        merge_done = 1'b1;
                        state_next = BACK_IDLE;
                        wa_next    = '0;
                        wb_next    = '0;
                        ia_next    = '0;
                        ib_next    = '0;
                    end
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
        out_valid_next = emit || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            wa_reg        <= '0;
            wb_reg        <= '0;
            ia_reg        <= '0;
            ib_reg        <= '0;
            ovf_reg       <= 1'b0;
            desc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wa_reg        <= wa_next;
            wb_reg        <= wb_next;
            ia_reg        <= ia_next;
            ib_reg        <= ib_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                desc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SLM_ASSERT_NOW(a_merge_in_range, state_reg == BACK_MERGE,
        (SW'(ia_reg) + SW'(ib_reg) < total) || (total == '0),
        "merge read indexes ran past the list lengths")
    `SLM_ASSERT_NEXT(a_done_clears, merge_done,
        (wa_reg == '0) && (wb_reg == '0) && (state_reg == BACK_IDLE),
        "lists not emptied after merge")
    `SLM_ASSERT_NOW(a_empty_is_last, out_valid_reg && out_data_reg.empty_res,
        out_data_reg.last && (out_data_reg.merged_value == '0),
        "empty merge result not flagged last with zero value")

endmodule

/* hdl/sorted_list_merge_core.sv */
// Two-way merge of sorted lists: top level joining front, command queue and back.
//
// Input channel in_valid/in_ready/in_data carries load-A, load-B and merge items;
// output channel out_valid/out_ready/out_data carries merged keys, one per transfer.
// Writing cfg_wr_en with cfg_wr_data selects descending (1) or ascending (0) order.
// Loads are taken one per cycle while no merge is under way and the two-entry
// command queue has room; each passes through the queue into its list RAM. A load
// into a full list is dropped and sets the overflow flag reported with the next
// merge. After a merge transfer the input is held off until its last result sits
// in the output register. The merge command passes through the queue to the back
// part, which enters its merge state and then gives one result per cycle into the
// output register while it is not stalled. The rate is set by the one read port of
// each list RAM, whose registered read supplies the next head every cycle.
// When out_ready is low the output register holds its result and the merge waits.
// Reset clears both list lengths, the overflow flag and the order bit; list RAM
// contents are left undefined and never reach a result before being written.
`timescale 1ns / 1ps

module sorted_list_merge_core
    import slm_pkg::*;
#(
    parameter int LIST_DEPTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_wr_en,
    input  logic     cfg_wr_data,
    input  logic     in_valid,
    output logic     in_ready,
    input  slm_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output slm_out_t out_data
);

    slm_q_status_t q_status;
    slm_cmd_t      q_push_data, q_pop_data;
    logic          q_push, q_pop, merge_done;

    slm_front #(.LIST_DEPTH(LIST_DEPTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_data     (q_push_data),
        .merge_done (merge_done)
    );

    slm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    slm_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_status    (q_status),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .merge_done  (merge_done),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

/* tb/sorted_list_merge_core_checker.sv */
// Merge checker: tracks both lists, predicts merged results and compares each transfer.
`timescale 1ns / 1ps

module sorted_list_merge_core_checker
    import slm_pkg::*;
#(
    parameter int LIST_DEPTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_wr_en,
    input  logic     cfg_wr_data,
    input  logic     in_valid,
    input  logic     in_ready,
    input  slm_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_ready,
    input  slm_out_t out_data,
    output int       fault_count,
    output int       results_outstanding
);

    logic signed [KEY_W-1:0] list_a_keys [LIST_DEPTH];
    logic signed [KEY_W-1:0] list_b_keys [LIST_DEPTH];
    int       len_a = 0;
    int       len_b = 0;
    bit       dropped_load = 1'b0;
    bit       desc_order = 1'b0;
    int       faults = 0;
    slm_out_t merged_q[$];

    task automatic check_field(input string field, input longint want_v, input longint got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            faults++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        slm_out_t got;
        slm_out_t want;
        int       ia;
        int       ib;
        int       total;
        bit       take_a;
        if (!rst_n)
        begin
            len_a = 0;
            len_b = 0;
            dropped_load = 1'b0;
            desc_order = 1'b0;
            merged_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
                desc_order = cfg_wr_data;

            if (out_valid && out_ready)
            begin
                got = out_data;
                if (merged_q.size() == 0)
                begin
                    $error("result with nothing pending: merged_value %0d last %0b",
                           $signed(got.merged_value), got.last);
                    faults++;
                end
                else
                begin
                    want = merged_q.pop_front();
                    check_field("merged_value", $signed(want.merged_value),
                                $signed(got.merged_value));
                    check_field("last", want.last, got.last);
                    check_field("empty_res", want.empty_res, got.empty_res);
                    check_field("overflow", want.overflow, got.overflow);
                end
            end

            if (in_valid && in_ready)
            begin
                case (in_data.kind)
                    KIND_LOAD_A:
                        if (len_a >= LIST_DEPTH)
                            dropped_load = 1'b1;
                        else
                            list_a_keys[len_a++] = in_data.value;
                    KIND_LOAD_B:
                        if (len_b >= LIST_DEPTH)
                            dropped_load = 1'b1;
                        else
                            list_b_keys[len_b++] = in_data.value;
                    KIND_MERGE:
                    begin
                        total = len_a + len_b;
                        want.empty_res = 1'b0;
                        want.overflow = dropped_load;
                        if (total == 0)
                        begin
                            want.merged_value = '0;
                            want.last = 1'b1;
                            want.empty_res = 1'b1;
                            merged_q.push_back(want);
                        end
                        else
                        begin
                            ia = 0;
                            ib = 0;
                            for (int k = 0; k < total; k++)
                            begin
                                // ties go to list A in both orders
                                if (ia >= len_a)
                                    take_a = 1'b0;
                                else if (ib >= len_b)
                                    take_a = 1'b1;
                                else if (desc_order)
                                    take_a = list_a_keys[ia] >= list_b_keys[ib];
                                else
                                    take_a = list_a_keys[ia] <= list_b_keys[ib];
                                if (take_a)
                                    want.merged_value = list_a_keys[ia++];
                                else
                                    want.merged_value = list_b_keys[ib++];
                                want.last = (k == total - 1);
                                merged_q.push_back(want);
                            end
                        end
                        len_a = 0;
                        len_b = 0;
                        dropped_load = 1'b0;
                    end
                    default:
                        ;
                endcase
            end
        end
        fault_count <= faults;
        results_outstanding <= merged_q.size();
    end

endmodule

/* tb/sorted_list_merge_core_test.sv */
// Top of the merge core test: clock, reset, load and merge traffic, output back-pressure, verdict.
`timescale 1ns / 1ps

module sorted_list_merge_core_test;
    import slm_pkg::*;

    localparam int LIST_DEPTH = 32;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam bit ORDER_ASC = 1'b0;
    localparam bit ORDER_DESC = 1'b1;
    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
    localparam longint KEY_TOP = 64'sd2147483647;
    localparam longint KEY_BOTTOM = -64'sd2147483648;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 20;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 1000;

    typedef logic signed [KEY_W-1:0] key_q_t[$];

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_wr_en = 1'b0;
    logic     cfg_wr_data = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    slm_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    slm_out_t out_data;

    int fault_count;
    int results_outstanding;
    int stall_cycles = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit long_hold_req = 1'b0;
    bit long_hold_done = 1'b0;
    bit desc_mode = ORDER_ASC;

    sorted_list_merge_core #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    sorted_list_merge_core_checker #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .in_data            (in_data),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .out_data           (out_data),
        .fault_count        (fault_count),
        .results_outstanding(results_outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: random short stalls, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("sorted_list_merge_core_test failed");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [KEY_W-1:0] value);
        slm_in_t item;
        item.kind = kind;
        item.value = value;
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Hold the sender until every pending result has been transferred.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_order(input bit order);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= order;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        desc_mode = order;
    endtask

    // Keys in the current merge order; scrambled lists of more than one key get one key replaced by a random value.
    function automatic key_q_t sorted_keys(input int n, input bit scrambled);
        key_q_t keys;
        longint k;
        longint step;
        k = longint'(int'($urandom));
        for (int i = 0; i < n; i++)
        begin
            keys.push_back(k[KEY_W-1:0]);
            step = longint'($urandom_range(0, 1 << $urandom_range(0, 28)));
            k = desc_mode ? k - step : k + step;
            if (k > KEY_TOP)
                k = KEY_TOP;
            if (k < KEY_BOTTOM)
                k = KEY_BOTTOM;
        end
        if (scrambled && n > 1)
            keys[$urandom_range(0, n - 1)] = $urandom;
        return keys;
    endfunction

    task automatic run_merge_set(input int na, input int nb, input bit scrambled);
        key_q_t a_keys;
        key_q_t b_keys;
        a_keys = sorted_keys(na, scrambled);
        b_keys = sorted_keys(nb, scrambled);
        while (a_keys.size() + b_keys.size() > 0)
        begin
            if ($urandom_range(0, 7) == 0)
                send_item(KIND_UNUSED, $urandom);
            if (b_keys.size() == 0 || (a_keys.size() != 0 && $urandom_range(0, 1) == 1))
                send_item(KIND_LOAD_A, a_keys.pop_front());
            else
                send_item(KIND_LOAD_B, b_keys.pop_front());
        end
        send_item(KIND_MERGE, $urandom);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_order(ORDER_ASC);

        // empty merge, ties at both extremes, one list only
        send_item(KIND_MERGE, 32'hFFFF_FFFF);
        send_item(KIND_LOAD_A, KEY_MIN);
        send_item(KIND_LOAD_B, KEY_MIN);
        send_item(KIND_LOAD_A, 32'h0000_0000);
        send_item(KIND_UNUSED, KEY_MAX);
        send_item(KIND_LOAD_B, 32'h0001_0000);
        send_item(KIND_LOAD_A, KEY_MAX);
        send_item(KIND_LOAD_B, KEY_MAX);
        send_item(KIND_MERGE, 32'h0000_0000);
        send_item(KIND_LOAD_A, 32'hFFFA_8000);
        send_item(KIND_LOAD_A, 32'h0003_0000);
        send_item(KIND_MERGE, KEY_MAX);
        send_item(KIND_LOAD_B, 32'h0007_0000);
        send_item(KIND_MERGE, KEY_MIN);

        set_order(ORDER_DESC);
        send_item(KIND_LOAD_A, KEY_MAX);
        send_item(KIND_LOAD_B, KEY_MAX);
        send_item(KIND_LOAD_A, 32'h0000_0000);
        send_item(KIND_LOAD_B, 32'hFFFF_FFFF);
        send_item(KIND_LOAD_A, KEY_MIN);
        send_item(KIND_LOAD_B, KEY_MIN);
        send_item(KIND_MERGE, 32'h5555_AAAA);

        set_order(ORDER_ASC);
        repeat (2)
            run_merge_set($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 3) == 0);
        run_merge_set(LIST_DEPTH + 1, 1, 1'b0);

        // stall the output while loads and merges keep coming
        long_hold_req = 1'b1;
        run_merge_set(6, 6, 1'b0);
        run_merge_set(2, 2, 1'b0);
        drain();

        set_order(ORDER_DESC);
        run_merge_set($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 3) == 0);

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_order(ORDER_ASC);
        run_merge_set($urandom_range(0, 6), $urandom_range(0, 6), 1'b0);
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fault_count == 0 && results_outstanding == 0)
            $display("sorted_list_merge_core_test passed");
        else
            $display("sorted_list_merge_core_test failed");
        $finish;
    end

endmodule

/* sorted_list_merge_core.f */
+incdir+hdl
hdl/slm_pkg.sv
hdl/slm_ram.sv
hdl/slm_queue.sv
hdl/slm_front.sv
hdl/slm_back.sv
hdl/sorted_list_merge_core.sv
tb/sorted_list_merge_core_checker.sv
tb/sorted_list_merge_core_test.sv
